>>> src/achd_pkg.sv
// Shared types, sizes and register indexes for the adjustment cell hot deck imputer.
`timescale 1ns / 1ps

package achd_pkg;

  // Default sizes of the top level.
  localparam int MAX_CELLS_DEF      = 64;
  localparam int NUM_COVARIATES_DEF = 4;
  localparam int NUM_FIELDS_DEF     = 4;

  // Fixed payload geometry.
  localparam int LANES     = 4;
  localparam int LANE_W    = 2;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_BASE   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_REGS    = 4'd8;

  typedef logic [LANES-1:0][DATA_W-1:0] lane_t;

  // Record travelling down the cell chain.
  typedef struct packed {
    lane_t            key;
    lane_t            fld;
    logic             done;
    logic             opened;
    logic [IDX_W-1:0] hit_idx;
  } tok_t;

  // Configuration seen by every cell.
  typedef struct packed {
    lane_t marker;
    lane_t init_val;
  } cfg_t;

endpackage

>>> src/achd_rec_in_if.sv
// Record input channel: valid, ready and one record.
`timescale 1ns / 1ps

interface achd_rec_in_if;
  logic                                valid;
  logic                                ready;
  logic                                start_of_set;
  logic signed [achd_pkg::DATA_W-1:0]  covariate_0;
  logic signed [achd_pkg::DATA_W-1:0]  covariate_1;
  logic signed [achd_pkg::DATA_W-1:0]  covariate_2;
  logic signed [achd_pkg::DATA_W-1:0]  covariate_3;
  logic signed [achd_pkg::DATA_W-1:0]  field_in_0;
  logic signed [achd_pkg::DATA_W-1:0]  field_in_1;
  logic signed [achd_pkg::DATA_W-1:0]  field_in_2;
  logic signed [achd_pkg::DATA_W-1:0]  field_in_3;

  modport source (
    output valid, start_of_set, covariate_0, covariate_1, covariate_2, covariate_3,
           field_in_0, field_in_1, field_in_2, field_in_3,
    input  ready
  );
  modport sink (
    input  valid, start_of_set, covariate_0, covariate_1, covariate_2, covariate_3,
           field_in_0, field_in_1, field_in_2, field_in_3,
    output ready
  );
endinterface

>>> src/achd_rec_out_if.sv
// Result output channel: valid, ready and one imputed record.
`timescale 1ns / 1ps

interface achd_rec_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [achd_pkg::DATA_W-1:0]  field_out_0;
  logic signed [achd_pkg::DATA_W-1:0]  field_out_1;
  logic signed [achd_pkg::DATA_W-1:0]  field_out_2;
  logic signed [achd_pkg::DATA_W-1:0]  field_out_3;
  logic        [achd_pkg::IDX_W-1:0]   cell_index;
  logic                                opened_cell;
  logic                                table_full;

  modport source (
    output valid, field_out_0, field_out_1, field_out_2, field_out_3,
           cell_index, opened_cell, table_full,
    input  ready
  );
  modport sink (
    input  valid, field_out_0, field_out_1, field_out_2, field_out_3,
           cell_index, opened_cell, table_full,
    output ready
  );
endinterface

>>> src/achd_cfg_if.sv
// Configuration write channel: valid, ready, register index and write data.
`timescale 1ns / 1ps

interface achd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [achd_pkg::CFG_IDX_W-1:0]     index;
  logic [achd_pkg::DATA_W-1:0]        wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

>>> src/adjustment_cell_hot_deck_imputer.sv
// Top level of the adjustment cell hot deck imputer: config registers, cell chain, result register.
`timescale 1ns / 1ps

// Sequential hot deck imputer over a bounded table of adjustment cells. Each record
// enters a head register and then walks a chain of MAX_CELLS cells, one cell per clock
// unless the chain is frozen by a tail item the full result register cannot take; cell n
// holds the covariate key and the last donor value of each field for the n-th opened
// cell. The first open cell whose key matches imputes the missing fields of the record
// and takes its present fields as new donors; an unmatched record opens the first free
// cell, filling missing fields from initial_value_k. A record that finds neither leaves
// the chain unchanged and is reported with table_full set. A record with start_of_set
// high empties the table before it is looked up. One record is in the chain at a time:
// the next record is accepted only once the previous one has left the chain for the
// result register. The result register parts the two sides, so the next record is taken
// while a result still waits. Configuration writes are always accepted; write them only
// while no record is in flight. Indexes beyond the register list are ignored.
module adjustment_cell_hot_deck_imputer #(
  parameter int MAX_CELLS      = achd_pkg::MAX_CELLS_DEF,
  parameter int NUM_COVARIATES = achd_pkg::NUM_COVARIATES_DEF,
  parameter int NUM_FIELDS     = achd_pkg::NUM_FIELDS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  achd_rec_in_if.sink    rec_i,
  achd_rec_out_if.source rec_o,
  achd_cfg_if.sink       cfg_i
);
  import achd_pkg::*;

  localparam int CNT_W = $clog2(MAX_CELLS + 1);

  // Configuration registers.
  lane_t marker_q, init_q;
  cfg_t  cfg;
  logic  [CFG_IDX_W-1:0] cfg_off;

  // Control.
  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             head_vld_q, head_vld_d;
  tok_t             head_tok_q, head_tok_d;
  logic             rec_acc, chain_adv, out_load;

  // Chain wiring: slot 0 is the head register, slot MAX_CELLS the tail.
  tok_t                 chain_tok [MAX_CELLS+1];
  logic [MAX_CELLS:0]   chain_vld;
  logic [MAX_CELLS-1:0] open_vec;

  // Result register.
  logic             out_vld_q, out_vld_d;
  lane_t            out_fld_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_opened_q, out_full_q;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;
  assign cfg_off     = cfg_i.index - CFG_INIT_BASE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LANES; k++) begin
        marker_q[k] <= {1'b1, {(DATA_W-1){1'b0}}};
        init_q[k]   <= '0;
      end
    end else if (cfg_i.valid && cfg_i.ready) begin
      // Drop writes beyond the register list.
      if (cfg_i.index < CFG_INIT_BASE) begin
        marker_q[cfg_i.index[LANE_W-1:0]] <= cfg_i.wdata;
      end else if (cfg_i.index < CFG_NUM_REGS) begin
        init_q[cfg_off[LANE_W-1:0]] <= cfg_i.wdata;
      end
    end
  end

  assign cfg.marker   = marker_q;
  assign cfg.init_val = init_q;

  // ---------------------------------------------------------------- input
  assign rec_i.ready = !busy_q;
  assign rec_acc     = rec_i.valid && rec_i.ready;

  // Freeze the chain only while a finished item sits in the tail and the result
  // register cannot take it.
  assign chain_adv = !(chain_vld[MAX_CELLS] && out_vld_q && !rec_o.ready);
  assign out_load  = chain_vld[MAX_CELLS] && chain_adv;

  always_comb begin
    head_tok_d         = head_tok_q;
    head_tok_d.key[0]  = rec_i.covariate_0;
    head_tok_d.key[1]  = rec_i.covariate_1;
    head_tok_d.key[2]  = rec_i.covariate_2;
    head_tok_d.key[3]  = rec_i.covariate_3;
    head_tok_d.fld[0]  = rec_i.field_in_0;
    head_tok_d.fld[1]  = rec_i.field_in_1;
    head_tok_d.fld[2]  = rec_i.field_in_2;
    head_tok_d.fld[3]  = rec_i.field_in_3;
    head_tok_d.done    = 1'b0;
    head_tok_d.opened  = 1'b0;
    head_tok_d.hit_idx = '0;

    // Hold the head valid only for the cycle the item sits there.
    if (rec_acc) begin
      head_vld_d = 1'b1;
    end else if (chain_adv) begin
      head_vld_d = 1'b0;
    end else begin
      head_vld_d = head_vld_q;
    end

    if (rec_acc) begin
      busy_d = 1'b1;
    end else if (out_load) begin
      busy_d = 1'b0;
    end else begin
      busy_d = busy_q;
    end

    // Empty the table on start of set; advance the fill count when a cell opens.
    if (rec_acc && rec_i.start_of_set) begin
      cnt_d = '0;
    end else if (|open_vec) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      head_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      busy_q     <= busy_d;
      head_vld_q <= head_vld_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_acc) begin
      head_tok_q <= head_tok_d;
    end
  end

  // ---------------------------------------------------------------- cell chain
  assign chain_tok[0] = head_tok_q;
  assign chain_vld[0] = head_vld_q;

  for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
    achd_cell #(
      .CELL_ID (i),
      .NUM_COV (NUM_COVARIATES),
      .NUM_FLD (NUM_FIELDS),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (chain_adv),
      .valid_i      (chain_vld[i]),
      .tok_i        (chain_tok[i]),
      .cfg_i        (cfg),
      .cells_used_i (cnt_q),
      .valid_o      (chain_vld[i+1]),
      .tok_o        (chain_tok[i+1]),
      .open_o       (open_vec[i])
    );
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (rec_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // An item that left the chain without being taken by a cell passes unchanged.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_fld_q    <= chain_tok[MAX_CELLS].fld;
      out_idx_q    <= chain_tok[MAX_CELLS].done ? chain_tok[MAX_CELLS].hit_idx : '0;
      out_opened_q <= chain_tok[MAX_CELLS].done && chain_tok[MAX_CELLS].opened;
      out_full_q   <= !chain_tok[MAX_CELLS].done;
    end
  end

  assign rec_o.valid       = out_vld_q;
  assign rec_o.field_out_0 = out_fld_q[0];
  assign rec_o.field_out_1 = out_fld_q[1];
  assign rec_o.field_out_2 = out_fld_q[2];
  assign rec_o.field_out_3 = out_fld_q[3];
  assign rec_o.cell_index  = out_idx_q;
  assign rec_o.opened_cell = out_opened_q;
  assign rec_o.table_full  = out_full_q;

  // ---------------------------------------------------------------- checks
  a_one_item_in_chain: assert property (
    @(posedge clk_i) disable iff (!rst_ni) $onehot0(chain_vld)
  ) else $error("more than one item in the cell chain");

  a_idle_chain_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !busy_q |-> (chain_vld == '0)
  ) else $error("item in the cell chain while idle");

  a_one_cell_opens: assert property (
    @(posedge clk_i) disable iff (!rst_ni) $onehot0(open_vec)
  ) else $error("more than one cell opened at once");

  a_fill_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(MAX_CELLS)
  ) else $error("fill count beyond table size");

endmodule

>>> src/achd_cell.sv
// One adjustment cell: stored key and donor values, match and update of a passing record.
`timescale 1ns / 1ps

module achd_cell #(
  parameter int CELL_ID = 0,
  parameter int NUM_COV = achd_pkg::NUM_COVARIATES_DEF,
  parameter int NUM_FLD = achd_pkg::NUM_FIELDS_DEF,
  parameter int CNT_W   = $clog2(achd_pkg::MAX_CELLS_DEF + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  achd_pkg::tok_t   tok_i,
  input  achd_pkg::cfg_t   cfg_i,
  input  logic [CNT_W-1:0] cells_used_i,
  output logic             valid_o,
  output achd_pkg::tok_t   tok_o,
  output logic             open_o
);
  import achd_pkg::*;

  lane_t key_q, key_d;
  lane_t donor_q, donor_d;
  tok_t  tok_q, tok_d;
  logic  valid_q;
  logic  is_open, key_eq, live, hit, open_cell;

  always_comb begin
    is_open = CNT_W'(CELL_ID) < cells_used_i;
    key_eq  = 1'b1;
    for (int c = 0; c < LANES; c++) begin
      if (c < NUM_COV && key_q[c] != tok_i.key[c]) begin
        key_eq = 1'b0;
      end
    end
    live      = valid_i && !tok_i.done;
    hit       = live && is_open && key_eq;
    open_cell = live && !is_open;

    tok_d   = tok_i;
    key_d   = key_q;
    donor_d = donor_q;
    if (hit) begin
      for (int k = 0; k < LANES; k++) begin
        if (k < NUM_FLD) begin
          if (tok_i.fld[k] == cfg_i.marker[k]) begin
            tok_d.fld[k] = donor_q[k];
          end else begin
            donor_d[k] = tok_i.fld[k];
          end
        end
      end
      tok_d.done    = 1'b1;
      tok_d.hit_idx = IDX_W'(CELL_ID);
    end else if (open_cell) begin
      for (int c = 0; c < LANES; c++) begin
        key_d[c] = (c < NUM_COV) ? tok_i.key[c] : '0;
      end
      for (int k = 0; k < LANES; k++) begin
        if (k < NUM_FLD) begin
          if (tok_i.fld[k] == cfg_i.marker[k]) begin
            tok_d.fld[k] = cfg_i.init_val[k];
          end
          donor_d[k] = tok_d.fld[k];
        end
      end
      tok_d.done    = 1'b1;
      tok_d.opened  = 1'b1;
      tok_d.hit_idx = IDX_W'(CELL_ID);
    end
  end

  assign open_o  = open_cell && en_i;
  assign valid_o = valid_q;
  assign tok_o   = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q   <= tok_d;
      key_q   <= key_d;
      donor_q <= donor_d;
    end
  end

endmodule

>>> tb/adjustment_cell_hot_deck_imputer_tb.sv
// Self-checking testbench for the adjustment cell hot deck imputer: predictor, stimulus and checks.
`timescale 1ns / 1ps

module adjustment_cell_hot_deck_imputer_tb;
  import achd_pkg::*;

  localparam int MAX_CELLS      = MAX_CELLS_DEF;
  localparam int NUM_COVARIATES = NUM_COVARIATES_DEF;
  localparam int NUM_FIELDS     = NUM_FIELDS_DEF;

  // Time to let pass once the last result is in, so that the chain runs empty.
  localparam int SETTLE_CYCLES = MAX_CELLS + 8;
  // Quiet cycles before the run is declared hung. The slowest correct item takes the
  // chain, a long sender gap and a long receiver stall burst; this is several times that.
  localparam int QUIET_LIMIT = 16 * (MAX_CELLS + 2) + 2000;
  localparam int RECORDS_PER_PHASE = 220;

  localparam int SENDER_IDLE_PCT   = 47;
  localparam int RECEIVER_STALL_PCT = 47;
  localparam int BOTH_IDLE_PCT     = 20;

  // Register index past the end of the list; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

  localparam logic [DATA_W-1:0] MIN_V    = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MAX_V    = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;
  localparam logic [DATA_W-1:0] ZERO_V   = '0;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // One record as sent, and the imputed result it must produce.
  typedef struct packed {
    logic  sos;
    lane_t key;
    lane_t fld;
  } record_t;

  typedef struct packed {
    lane_t            fld;
    logic [IDX_W-1:0] cell_idx;
    logic             opened;
    logic             full;
  } imputed_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  achd_rec_in_if  rec_in ();
  achd_rec_out_if rec_out ();
  achd_cfg_if     cfg ();

  adjustment_cell_hot_deck_imputer #(
    .MAX_CELLS     (MAX_CELLS),
    .NUM_COVARIATES(NUM_COVARIATES),
    .NUM_FIELDS    (NUM_FIELDS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rec_i (rec_in),
    .rec_o (rec_out),
    .cfg_i (cfg)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: our own copy of the cell table and the registers.
  lane_t    cell_key   [MAX_CELLS];
  lane_t    cell_donor [MAX_CELLS];
  int       open_cells;
  lane_t    marker_cfg;
  lane_t    init_cfg;
  imputed_t pending_imputations[$];

  int errors;
  int n_records;
  int n_opened;
  int n_filled;
  int n_full;
  int n_cfg_writes;
  int sender_idle_pct;
  int receiver_stall_pct;
  int stall_burst;
  int quiet_cycles;

  // Predict the result of one accepted record and advance the table copy.
  function automatic imputed_t impute_record(record_t r);
    imputed_t res;
    int       hit;
    int       c;
    int       k;
    bit       same;
    res.fld      = r.fld;
    res.cell_idx = '0;
    res.opened   = 1'b0;
    res.full     = 1'b0;
    hit          = -1;
    if (r.sos) begin
      open_cells = 0;
    end
    // First open cell whose used covariates all match wins.
    for (c = 0; c < open_cells && hit < 0; c++) begin
      same = 1'b1;
      for (k = 0; k < NUM_COVARIATES; k++) begin
        if (cell_key[c][k] != r.key[k]) same = 1'b0;
      end
      if (same) hit = c;
    end
    if (hit >= 0) begin
      // Fill missing fields from the donor, refresh the donor from present ones.
      for (k = 0; k < NUM_FIELDS; k++) begin
        if (r.fld[k] == marker_cfg[k]) begin
          res.fld[k] = cell_donor[hit][k];
          n_filled++;
        end else begin
          cell_donor[hit][k] = r.fld[k];
        end
      end
      res.cell_idx = IDX_W'(hit);
    end else if (open_cells < MAX_CELLS) begin
      // Open the next free cell, seeding missing fields from the initial values.
      cell_key[open_cells] = r.key;
      for (k = 0; k < NUM_FIELDS; k++) begin
        if (r.fld[k] == marker_cfg[k]) res.fld[k] = init_cfg[k];
        cell_donor[open_cells][k] = res.fld[k];
      end
      res.cell_idx = IDX_W'(open_cells);
      res.opened   = 1'b1;
      open_cells++;
      n_opened++;
    end else begin
      // No match and no room: pass through untouched.
      res.full = 1'b1;
      n_full++;
    end
    return res;
  endfunction

  function automatic lane_t lanes(logic [DATA_W-1:0] a0, logic [DATA_W-1:0] a1,
                                  logic [DATA_W-1:0] a2, logic [DATA_W-1:0] a3);
    lane_t l;
    l[0] = a0;
    l[1] = a1;
    l[2] = a2;
    l[3] = a3;
    return l;
  endfunction

  function automatic record_t make_record(logic sos, lane_t key, lane_t fld);
    record_t r;
    r.sos = sos;
    r.key = key;
    r.fld = fld;
    return r;
  endfunction

  // Mostly full-range random words, with the corners of the signed range now and then.
  function automatic logic [DATA_W-1:0] corner_or_random();
    if ($urandom_range(0, 99) >= 25) return $urandom;
    case ($urandom_range(0, 3))
      0:       return MIN_V;
      1:       return MAX_V;
      2:       return ZERO_V;
      default: return ALL_ONES;
    endcase
  endfunction

  function automatic lane_t random_lanes();
    lane_t l;
    for (int k = 0; k < LANES; k++) l[k] = corner_or_random();
    return l;
  endfunction

  // Field values: the marker often, near misses of it, corners, and plain random words.
  function automatic lane_t random_fields();
    lane_t l;
    int    pick;
    for (int k = 0; k < LANES; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      l[k] = marker_cfg[k];
      else if (pick < 40) l[k] = marker_cfg[k] + 1;
      else if (pick < 45) l[k] = marker_cfg[k] - 1;
      else                l[k] = corner_or_random();
    end
    return l;
  endfunction

  task automatic set_idling(input idle_mode_e m);
    sender_idle_pct    = (m == IDLE_SENDER) ? SENDER_IDLE_PCT :
                         (m == IDLE_BOTH)   ? BOTH_IDLE_PCT : 0;
    receiver_stall_pct = (m == IDLE_RECEIVER) ? RECEIVER_STALL_PCT :
                         (m == IDLE_BOTH)     ? BOTH_IDLE_PCT : 0;
  endtask

  // Send one record and predict its result when it is accepted. Valid stays high on
  // return, so back-to-back items never lower and raise it in the same step.
  task automatic send_record(input record_t r);
    int gap;
    gap = 0;
    if (sender_idle_pct != 0) begin
      // Mostly short gaps; now and then a long one so idling lands mid-chain too.
      if ($urandom_range(0, 99) < 12) gap = $urandom_range(1, MAX_CELLS + 8);
      else while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    end
    if (gap != 0) begin
      rec_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rec_in.valid        <= 1'b1;
    rec_in.start_of_set <= r.sos;
    rec_in.covariate_0  <= r.key[0];
    rec_in.covariate_1  <= r.key[1];
    rec_in.covariate_2  <= r.key[2];
    rec_in.covariate_3  <= r.key[3];
    rec_in.field_in_0   <= r.fld[0];
    rec_in.field_in_1   <= r.fld[1];
    rec_in.field_in_2   <= r.fld[2];
    rec_in.field_in_3   <= r.fld[3];
    do @(posedge clk_i); while (rec_in.ready !== 1'b1);
    pending_imputations.push_back(impute_record(r));
    n_records++;
  endtask

  // Drop valid, wait for every expected result, then let the chain run empty.
  task automatic drain_results();
    rec_in.valid <= 1'b0;
    while (pending_imputations.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
    logic [CFG_IDX_W-1:0] marker_off;
    logic [CFG_IDX_W-1:0] init_off;
    marker_off = idx - CFG_MARKER_BASE;
    init_off   = idx - CFG_INIT_BASE;
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= v;
    do @(posedge clk_i); while (cfg.ready !== 1'b1);
    if (idx < CFG_INIT_BASE)     marker_cfg[marker_off[LANE_W-1:0]] = v;
    else if (idx < CFG_NUM_REGS) init_cfg[init_off[LANE_W-1:0]]     = v;
    n_cfg_writes++;
  endtask

  // Write all markers and initial values; slip in writes past the list that must be dropped.
  task automatic load_config(input lane_t markers, input lane_t inits);
    for (int k = 0; k < LANES; k++) write_reg(CFG_MARKER_BASE + CFG_IDX_W'(k), markers[k]);
    write_reg(CFG_NUM_REGS, $urandom);
    for (int k = 0; k < LANES; k++) write_reg(CFG_INIT_BASE + CFG_IDX_W'(k), inits[k]);
    write_reg(CFG_IDX_TOP, $urandom);
    cfg.valid <= 1'b0;
  endtask

  // Reset registers: marker is the most negative value, initial values are zero.
  task automatic test_reset_defaults();
    set_idling(IDLE_NONE);
    // First record of a set with every field missing takes the initial values.
    send_record(make_record(1'b1, lanes(ZERO_V, ZERO_V, ZERO_V, ZERO_V),
                            lanes(MIN_V, MIN_V, MIN_V, MIN_V)));
    send_record(make_record(1'b0, lanes(ZERO_V, ZERO_V, ZERO_V, ZERO_V),
                            lanes(MAX_V, ALL_ONES, 32'd1, ZERO_V)));
    // Partly missing: fill from the donors just stored.
    send_record(make_record(1'b0, lanes(ZERO_V, ZERO_V, ZERO_V, ZERO_V),
                            lanes(MIN_V, MIN_V, 32'd5, MIN_V)));
    send_record(make_record(1'b0, lanes(MAX_V, MIN_V, ALL_ONES, 32'd1),
                            lanes(MIN_V + 1, MAX_V - 1, MIN_V, 32'd7)));
    // Key differs in the last covariate only: must open its own cell.
    send_record(make_record(1'b0, lanes(MAX_V, MIN_V, ALL_ONES, ZERO_V),
                            lanes(MIN_V, MIN_V, MIN_V, MIN_V)));
    send_record(make_record(1'b0, lanes(MAX_V, MIN_V, ALL_ONES, 32'd1),
                            lanes(MIN_V, MIN_V, MIN_V, MIN_V)));
    // Start of set clears the table: same key reopens at cell zero.
    send_record(make_record(1'b1, lanes(MAX_V, MIN_V, ALL_ONES, 32'd1),
                            lanes(MIN_V, 32'd3, MIN_V, MIN_V)));
    drain_results();
  endtask

  // Markers and initial values at the extremes of their range.
  task automatic test_register_extremes();
    lane_t markers;
    markers = lanes(MAX_V, ZERO_V, ALL_ONES, MIN_V);
    set_idling(IDLE_NONE);
    load_config(markers, lanes(MIN_V, MAX_V, 32'h5a5a_a5a5, ALL_ONES));
    send_record(make_record(1'b1, lanes(MIN_V, MIN_V, MIN_V, MIN_V), markers));
    send_record(make_record(1'b0, lanes(MIN_V, MIN_V, MIN_V, MIN_V),
                            lanes(MIN_V, MAX_V, ZERO_V, MAX_V)));
    send_record(make_record(1'b0, lanes(MIN_V, MIN_V, MIN_V, MIN_V), markers));
    // One off the marker is present, not missing.
    send_record(make_record(1'b0, lanes(MAX_V, MAX_V, MAX_V, MAX_V),
                            lanes(MAX_V - 1, 32'd1, ALL_ONES - 1, MIN_V + 1)));
    send_record(make_record(1'b0, lanes(MAX_V, MAX_V, MAX_V, MAX_V),
                            lanes(MAX_V, ZERO_V, 32'd5, MIN_V)));
    drain_results();
  endtask

  // Fill every cell, then push unmatched records (full) mixed with matched ones.
  task automatic test_table_full();
    record_t r;
    lane_t   base;
    lane_t   opened_keys[$];
    set_idling(IDLE_BOTH);
    load_config(random_lanes(), random_lanes());
    base = random_lanes();
    for (int i = 0; i < MAX_CELLS; i++) begin
      r.sos    = (i == 0);
      r.key    = base;
      r.key[0] = base[0] + DATA_W'(i);
      r.fld    = random_fields();
      opened_keys.push_back(r.key);
      send_record(r);
    end
    for (int i = 0; i < 16; i++) begin
      r.sos = 1'b0;
      if (i % 2 == 1) begin
        r.key = opened_keys[$urandom_range(0, opened_keys.size() - 1)];
      end else begin
        r.key    = base;
        r.key[0] = base[0] + DATA_W'(MAX_CELLS + i);
      end
      r.fld = random_fields();
      send_record(r);
    end
    // A new set frees the whole table again.
    send_record(make_record(1'b1, base, random_fields()));
    drain_results();
  endtask

  // Random records over a small pool of keys, one idling mode per phase.
  task automatic test_random_phases();
    idle_mode_e m;
    lane_t      pool[$];
    lane_t      key;
    record_t    r;
    m = m.first();
    do begin
      set_idling(m);
      load_config(random_lanes(), random_lanes());
      // Neighbouring pool keys often differ in a single covariate.
      pool.delete();
      pool.push_back(random_lanes());
      repeat ($urandom_range(3, 11)) begin
        key = pool[pool.size() - 1];
        if ($urandom_range(0, 1) == 0) key = random_lanes();
        else key[$urandom_range(0, LANES - 1)] = corner_or_random();
        pool.push_back(key);
      end
      for (int i = 0; i < RECORDS_PER_PHASE; i++) begin
        r.sos = ($urandom_range(0, 39) == 0);
        if ($urandom_range(0, 99) < 88) r.key = pool[$urandom_range(0, pool.size() - 1)];
        else r.key = random_lanes();
        r.fld = random_fields();
        send_record(r);
      end
      drain_results();
      m = m.next();
    end while (m != m.first());
  endtask

  // Receiver: random stalls, with occasional long bursts so a result waits in the
  // output register while the next record walks the chain.
  always @(posedge clk_i) begin
    if (stall_burst > 0) begin
      stall_burst--;
      rec_out.ready <= 1'b0;
    end else if (receiver_stall_pct != 0 && $urandom_range(0, 999) < 15) begin
      stall_burst = $urandom_range(1, 2 * MAX_CELLS);
      rec_out.ready <= 1'b0;
    end else begin
      rec_out.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Check each accepted result against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    imputed_t want;
    lane_t    got;
    if (rst_ni && rec_out.valid && rec_out.ready) begin
      got[0] = rec_out.field_out_0;
      got[1] = rec_out.field_out_1;
      got[2] = rec_out.field_out_2;
      got[3] = rec_out.field_out_3;
      if (pending_imputations.size() == 0) begin
        $error("result with no record outstanding: cell_index %0d", rec_out.cell_index);
        errors++;
      end else begin
        want = pending_imputations.pop_front();
        for (int k = 0; k < LANES; k++) begin
          if (got[k] !== want.fld[k]) begin
            $error("field_out_%0d: expected %0d, got %0d", k,
                   $signed(want.fld[k]), $signed(got[k]));
            errors++;
          end
        end
        if (rec_out.cell_index !== want.cell_idx) begin
          $error("cell_index: expected %0d, got %0d", want.cell_idx, rec_out.cell_index);
          errors++;
        end
        if (rec_out.opened_cell !== want.opened) begin
          $error("opened_cell: expected %0b, got %0b", want.opened, rec_out.opened_cell);
          errors++;
        end
        if (rec_out.table_full !== want.full) begin
          $error("table_full: expected %0b, got %0b", want.full, rec_out.table_full);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no channel moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (rec_in.valid && rec_in.ready) || (rec_out.valid && rec_out.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no item moved for %0d cycles, %0d results outstanding", quiet_cycles,
             pending_imputations.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    // Hold every input at a known value before the first edge.
    rst_ni              = 1'b0;
    rec_in.valid        = 1'b0;
    rec_in.start_of_set = 1'b0;
    rec_in.covariate_0  = '0;
    rec_in.covariate_1  = '0;
    rec_in.covariate_2  = '0;
    rec_in.covariate_3  = '0;
    rec_in.field_in_0   = '0;
    rec_in.field_in_1   = '0;
    rec_in.field_in_2   = '0;
    rec_in.field_in_3   = '0;
    rec_out.ready       = 1'b0;
    cfg.valid           = 1'b0;
    cfg.index           = '0;
    cfg.wdata           = '0;
    errors              = 0;
    n_records           = 0;
    n_opened            = 0;
    n_filled            = 0;
    n_full              = 0;
    n_cfg_writes        = 0;
    stall_burst         = 0;
    quiet_cycles        = 0;
    open_cells          = 0;
    for (int k = 0; k < LANES; k++) begin
      marker_cfg[k] = MIN_V;
      init_cfg[k]   = ZERO_V;
    end
    set_idling(IDLE_NONE);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_table_full();
    test_random_phases();

    drain_results();
    if (pending_imputations.size() != 0) begin
      $error("%0d predicted results never arrived", pending_imputations.size());
      errors++;
    end
    $display("Ran %0d records through %0d register writes: %0d cells opened, %0d fields filled",
             n_records, n_cfg_writes, n_opened, n_filled);
    $display("from donors, %0d full-table passes; idling off, sender, receiver, both; %0d errors",
             n_full, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
